// ===== rtl/core/msfd_pkg.sv =====
// shared types, constants and helpers for the multi-server fifo dispatcher
package msfd_pkg;

  localparam int unsigned QueueSlots  = 16;
  localparam int unsigned WorkerCount = 2;

  localparam int unsigned PtrW  = $clog2(QueueSlots);
  localparam int unsigned WkW   = (WorkerCount > 1) ? $clog2(WorkerCount) : 1;
  localparam int unsigned IdW   = 16;
  localparam int unsigned TickW = 16;
  localparam int unsigned SvcW  = 4;
  localparam int unsigned SumW  = 32;
  localparam int unsigned LvlW  = 4;

  typedef logic [PtrW-1:0] ptr_t;
  typedef logic [WkW-1:0]  wk_idx_t;

  typedef enum logic [1:0] {
    ActRest  = 2'd0,
    ActServe = 2'd1,
    ActStart = 2'd2
  } action_e;

  typedef struct packed {
    logic            arrival;
    logic [SvcW-1:0] job_service;
  } in_t;

  typedef struct packed {
    logic             worker_index;
    action_e          action;
    logic [IdW-1:0]   job_id;
    logic [TickW-1:0] wait_ticks;
    logic             arrival_dropped;
    logic [SumW-1:0]  wait_total;
    logic [LvlW-1:0]  queue_level;
    logic             last;
  } out_t;

  // one queue entry: id, arrival tick, service time
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TickW-1:0] arrived;
    logic [SvcW-1:0]  service;
  } job_t;

  // queue status seen by the rest of the block
  typedef struct packed {
    logic empty;
    logic full;
    ptr_t level;
  } q_stat_t;

  // one worker step as reported by the worker unit
  typedef struct packed {
    action_e          action;
    logic [IdW-1:0]   job_id;
    logic [TickW-1:0] wait_ticks;
    logic [SumW-1:0]  wait_total;
  } wk_res_t;

  function automatic ptr_t slot_after(ptr_t p);
    ptr_t r;
    if (p == PtrW'(QueueSlots - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/msfd_job_queue.sv =====
// circular job queue in a synchronous memory with a prefetched head entry
module msfd_job_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_en_i,
  input  msfd_pkg::job_t   push_job_i,
  input  logic             pop_en_i,
  output msfd_pkg::job_t   head_job_o,
  output msfd_pkg::q_stat_t q_stat_o
);

  msfd_pkg::job_t mem_q [msfd_pkg::QueueSlots];
  msfd_pkg::job_t head_rd_q;
  msfd_pkg::ptr_t head_q, head_d;
  msfd_pkg::ptr_t tail_q, tail_d;

  // head after this cycle's pop, full and level seen after the pop
  always_comb begin
    head_d = pop_en_i ? msfd_pkg::slot_after(head_q) : head_q;
    tail_d = push_en_i ? msfd_pkg::slot_after(tail_q) : tail_q;
    q_stat_o.empty = (head_q == tail_q);
    q_stat_o.full  = (msfd_pkg::slot_after(tail_q) == head_d);
    if (tail_q >= head_d) begin
      q_stat_o.level = tail_q - head_d;
    end else begin
      q_stat_o.level = tail_q + msfd_pkg::PtrW'(msfd_pkg::QueueSlots) - head_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  // write port at the tail, read port prefetches the next head
  always_ff @(posedge clk_i) begin
    if (push_en_i) begin
      mem_q[tail_q] <= push_job_i;
    end
  end

  // bypass a write that lands on the entry being prefetched
  always_ff @(posedge clk_i) begin
    if (push_en_i && (tail_q == head_d)) begin
      head_rd_q <= push_job_i;
    end else begin
      head_rd_q <= mem_q[head_d];
    end
  end

  assign head_job_o = head_rd_q;

endmodule

// ===== rtl/core/msfd_worker_unit.sv =====
// per-worker service counters, dispatch decision and saturating wait total
module msfd_worker_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_en_i,
  input  msfd_pkg::wk_idx_t             wk_i,
  input  logic [msfd_pkg::TickW-1:0]    cur_tick_i,
  input  logic                          q_empty_i,
  input  msfd_pkg::job_t                head_job_i,
  output logic                          pop_o,
  output msfd_pkg::wk_res_t             res_o
);

  logic [msfd_pkg::SvcW-1:0]  rem_q  [msfd_pkg::WorkerCount];
  logic [msfd_pkg::IdW-1:0]   serv_q [msfd_pkg::WorkerCount];
  logic [msfd_pkg::SumW-1:0]  sum_q, sum_d;
  logic [msfd_pkg::SumW:0]    sum_ext;
  logic [msfd_pkg::TickW-1:0] wait_ticks;
  logic                       busy;

  always_comb begin
    busy       = (rem_q[wk_i] != '0);
    pop_o      = step_en_i && !busy && !q_empty_i;
    wait_ticks = cur_tick_i - head_job_i.arrived;
    sum_ext    = {1'b0, sum_q} + {{(msfd_pkg::SumW + 1 - msfd_pkg::TickW){1'b0}}, wait_ticks};
    sum_d      = sum_q;
    res_o      = '{action: msfd_pkg::ActRest, job_id: '0, wait_ticks: '0, wait_total: sum_q};
    if (busy) begin
      res_o.action = msfd_pkg::ActServe;
      res_o.job_id = serv_q[wk_i];
    end else if (!q_empty_i) begin
      sum_d = sum_ext[msfd_pkg::SumW] ? '1 : sum_ext[msfd_pkg::SumW-1:0];
      res_o.action     = msfd_pkg::ActStart;
      res_o.job_id     = head_job_i.id;
      res_o.wait_ticks = wait_ticks;
      res_o.wait_total = sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < msfd_pkg::WorkerCount; i++) begin
        rem_q[i]  <= '0;
        serv_q[i] <= '0;
      end
      sum_q <= '0;
    end else if (step_en_i) begin
      if (busy) begin
        rem_q[wk_i] <= rem_q[wk_i] - msfd_pkg::SvcW'(1);
      end else if (!q_empty_i) begin
        rem_q[wk_i]  <= head_job_i.service;
        serv_q[wk_i] <= head_job_i.id;
        sum_q        <= sum_d;
      end
    end
  end

endmodule

// ===== rtl/core/multi_server_fifo_dispatcher_top.sv =====
// top level of the multi-server fifo dispatcher: tick sequencer and result register
//
// Each input transaction is one tick: an optional arriving job and its service
// time. An arrival is stamped with the next job id and the tick count and pushed
// into a circular queue held in a one-port-write, one-port-read memory of
// QueueSlots entries (at most QueueSlots-1 jobs waiting); when the queue is full
// the job is dropped and arrival_dropped is set on every result of that tick.
// The workers are then stepped one per cycle in index order, each giving one
// result transaction, the last one flagged by last. They step one at a time
// because the shared queue head can be popped by at most one worker per cycle,
// as each pop prefetches the next head entry from the memory. The next tick
// is accepted in the cycle of the current tick's last worker step, so ticks
// follow back to back when the result side keeps up. A stalled result holds
// the worker sequence; an idle block accepts a tick even while a result still
// waits. There is no clearing pass after reset.
module multi_server_fifo_dispatcher_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  msfd_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output msfd_pkg::out_t out_data_o
);

  localparam msfd_pkg::wk_idx_t LastWk = msfd_pkg::WkW'(msfd_pkg::WorkerCount - 1);

  // tick sequencer
  logic              active_q, active_d;
  msfd_pkg::wk_idx_t wk_q, wk_d;
  logic              step_en;
  logic              last_step;
  logic              accept;

  // tick context
  logic [msfd_pkg::TickW-1:0] tick_q, tick_d;
  logic [msfd_pkg::TickW-1:0] cur_tick_q;
  logic [msfd_pkg::IdW-1:0]   next_id_q, next_id_d;
  logic                       dropped_q;

  // queue and worker connections
  logic              push_en;
  msfd_pkg::job_t    push_job;
  logic              pop_en;
  msfd_pkg::job_t    head_job;
  msfd_pkg::q_stat_t q_stat;
  msfd_pkg::wk_res_t wk_res;

  // result register
  logic           out_valid_q, out_valid_d;
  msfd_pkg::out_t out_q;

  // a worker steps when the result register is free or being drained
  assign step_en    = active_q && (!out_valid_q || out_ready_i);
  assign last_step  = step_en && (wk_q == LastWk);
  assign in_ready_o = !active_q || last_step;
  assign accept     = in_valid_i && in_ready_o;

  // push happens in the accept cycle, after any pop of the tick being finished
  assign push_en  = accept && in_data_i.arrival && !q_stat.full;
  assign push_job = '{id: next_id_q, arrived: tick_q, service: in_data_i.job_service};

  always_comb begin
    active_d  = active_q;
    wk_d      = wk_q;
    tick_d    = tick_q;
    next_id_d = next_id_q;
    if (accept) begin
      active_d = 1'b1;
      wk_d     = '0;
      tick_d   = tick_q + msfd_pkg::TickW'(1);
    end else if (last_step) begin
      active_d = 1'b0;
    end else if (step_en) begin
      wk_d = wk_q + msfd_pkg::WkW'(1);
    end
    if (push_en) begin
      next_id_d = next_id_q + msfd_pkg::IdW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      wk_q      <= '0;
      tick_q    <= '0;
      next_id_q <= '0;
    end else begin
      active_q  <= active_d;
      wk_q      <= wk_d;
      tick_q    <= tick_d;
      next_id_q <= next_id_d;
    end
  end

  // per-tick context, payload only
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_tick_q <= tick_q;
      dropped_q  <= in_data_i.arrival && q_stat.full;
    end
  end

  msfd_job_queue u_job_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_en_i  (push_en),
    .push_job_i (push_job),
    .pop_en_i   (pop_en),
    .head_job_o (head_job),
    .q_stat_o   (q_stat)
  );

  msfd_worker_unit u_worker_unit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_en_i  (step_en),
    .wk_i       (wk_q),
    .cur_tick_i (cur_tick_q),
    .q_empty_i  (q_stat.empty),
    .head_job_i (head_job),
    .pop_o      (pop_en),
    .res_o      (wk_res)
  );

  // result register: loads on a worker step, drains on out_ready_i
  always_comb begin
    out_valid_d = out_valid_q;
    if (step_en) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      out_q.worker_index    <= wk_q[0];
      out_q.action          <= wk_res.action;
      out_q.job_id          <= wk_res.job_id;
      out_q.wait_ticks      <= wk_res.wait_ticks;
      out_q.arrival_dropped <= dropped_q;
      out_q.wait_total      <= wk_res.wait_total;
      out_q.queue_level     <= msfd_pkg::LvlW'(q_stat.level);
      out_q.last            <= (wk_q == LastWk);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
